// ===== rtl/core/alrp_pkg.sv =====
// Shared types, constants and helpers for the ASCII length-prefixed record parser.
package alrp_pkg;

  localparam int HEADER_DIGITS = 4;
  localparam int DIG_W = (HEADER_DIGITS > 1) ? $clog2(HEADER_DIGITS) : 1;
  localparam int ACC_W = 14;
  localparam int BYTE_W = 8;
  localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(9999);
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

  typedef enum logic [1:0] {
    PH_OP  = 2'd0,
    PH_LEN = 2'd1,
    PH_PAY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_HEADER = 2'd1,
    ERR_TRUNC  = 2'd2
  } err_t;

  typedef struct packed {
    phase_t             phase;
    logic [DIG_W-1:0]   digit_idx;
    logic [ACC_W-1:0]   op_acc;
    logic [ACC_W-1:0]   len_acc;
    logic [ACC_W-1:0]   remaining;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_OP,
    digit_idx: '0,
    op_acc:    '0,
    len_acc:   '0,
    remaining: '0
  };

  typedef struct packed {
    logic [ACC_W-1:0]  op_code;
    logic [ACC_W-1:0]  record_length;
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_valid;
    logic              last_in_record;
    err_t              error_code;
  } out_word_t;

  typedef struct packed {
    logic      emit;
    out_word_t word;
  } result_t;

  // acc * 10 + d, saturated
  function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [ACC_W+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (ACC_W+4)'(d);
    return (v > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/core/alrp_in_if.sv =====
// Input channel: one message byte per word with end-of-message mark.
interface alrp_in_if;
  import alrp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_message;

  modport source(output valid, output in_byte, output end_of_message, input ready);
  modport sink(input valid, input in_byte, input end_of_message, output ready);
endinterface

// ===== rtl/core/alrp_out_if.sv =====
// Result channel: one payload byte, header values and status per word.
interface alrp_out_if;
  import alrp_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACC_W-1:0]  op_code;
  logic [ACC_W-1:0]  record_length;
  logic [BYTE_W-1:0] payload_byte;
  logic              byte_valid;
  logic              last_in_record;
  logic [1:0]        error_code;

  modport source(output valid, output op_code, output record_length, output payload_byte,
                 output byte_valid, output last_in_record, output error_code,
                 input ready);
  modport sink(input valid, input op_code, input record_length, input payload_byte,
               input byte_valid, input last_in_record, input error_code,
               output ready);
endinterface

// ===== rtl/core/alrp_step.sv =====
// Per-byte parse step: next parser state and the optional result word.
module alrp_step (
  input  alrp_pkg::state_t           state,
  input  logic [alrp_pkg::BYTE_W-1:0] data_byte,
  input  logic                        eom,
  output alrp_pkg::state_t           state_nxt,
  output alrp_pkg::result_t          res
);
  import alrp_pkg::*;

  logic             is_digit;
  logic             last_digit;
  logic             pay_last;
  logic [ACC_W-1:0] op_new;
  logic [ACC_W-1:0] len_new;

  assign is_digit   = (data_byte >= ASCII_ZERO) && (data_byte <= ASCII_NINE);
  assign last_digit = (state.digit_idx == DIG_W'(HEADER_DIGITS - 1));
  assign pay_last   = (state.remaining <= ACC_W'(1));
  assign op_new     = acc_digit(state.op_acc, data_byte[3:0]);
  assign len_new    = acc_digit(state.len_acc, data_byte[3:0]);

  // next state
  always_comb begin
    state_nxt = state;
    unique case (state.phase)
      PH_PAY: begin
        if (pay_last || eom) begin
          state_nxt = STATE_RESET;
        end else begin
          state_nxt.remaining = state.remaining - ACC_W'(1);
        end
      end
      PH_OP, PH_LEN: begin
        if (!is_digit) begin
          state_nxt = STATE_RESET;
        end else begin
          if (state.phase == PH_OP) begin
            state_nxt.op_acc = op_new;
          end else begin
            state_nxt.len_acc = len_new;
          end
          if (last_digit) begin
            state_nxt.digit_idx = '0;
            if (state.phase == PH_OP) begin
              state_nxt.phase = PH_LEN;
            end else if (len_new == '0) begin
              state_nxt = STATE_RESET;
            end else begin
              state_nxt.phase     = PH_PAY;
              state_nxt.remaining = len_new;
            end
          end else begin
            state_nxt.digit_idx = state.digit_idx + DIG_W'(1);
          end
          if (eom) begin
            state_nxt = STATE_RESET;
          end
        end
      end
      default: begin
        state_nxt = STATE_RESET;
      end
    endcase
  end

  // result word
  always_comb begin
    res.emit                = 1'b0;
    res.word.op_code        = state.op_acc;
    res.word.record_length  = state.len_acc;
    res.word.payload_byte   = '0;
    res.word.byte_valid     = 1'b0;
    res.word.last_in_record = 1'b1;
    res.word.error_code     = ERR_NONE;
    unique case (state.phase)
      PH_PAY: begin
        res.emit = 1'b1;
        if (pay_last) begin
          res.word.payload_byte = data_byte;
          res.word.byte_valid   = 1'b1;
        end else if (eom) begin
          res.word.error_code = ERR_TRUNC;
        end else begin
          res.word.payload_byte   = data_byte;
          res.word.byte_valid     = 1'b1;
          res.word.last_in_record = 1'b0;
        end
      end
      PH_OP, PH_LEN: begin
        if (!is_digit) begin
          res.emit            = 1'b1;
          res.word.error_code = ERR_HEADER;
        end else begin
          if (state.phase == PH_OP) begin
            res.word.op_code = op_new;
          end else begin
            res.word.record_length = len_new;
          end
          if ((state.phase == PH_LEN) && last_digit && (len_new == '0)) begin
            res.emit = 1'b1;
          end else if (eom) begin
            res.emit            = 1'b1;
            res.word.error_code = ERR_TRUNC;
          end
        end
      end
      default: begin
        res.emit = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/ascii_length_prefixed_record_parser.sv =====
// Top level of the ASCII length-prefixed record parser.
// Takes one message byte per clock while the output is not stalled and returns at most one
// result word per byte. Each record is four ASCII decimal digits of operation code, four of
// payload length, then the payload; every payload byte comes out with the code, the length
// and a last-of-record mark, and a zero-length record gives one word with byte_valid low. A
// non-digit header byte (error 1) or an end of message inside a record (error 2) gives one
// error word and the parser starts over at the next header. Sustained rate is one byte per
// clock when the output does not stall. A byte goes from the input register through the
// combinational parse step into the result register, which drives the output.
// A waiting result stalls only bytes that give a result word: header digits that give none
// still pass the input register, and any other byte waits until the result register is free.
module ascii_length_prefixed_record_parser (
  input logic       clk,
  input logic       rst_n,
  alrp_in_if.sink   in_ch,
  alrp_out_if.source out_ch
);
  import alrp_pkg::*;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_eom_r;
  logic              s1_adv;
  logic              out_free;
  logic              out_valid_r;
  out_word_t         out_word_r;
  state_t            state_r;
  state_t            state_nxt;
  result_t           res;

  alrp_step u_step (
    .state     (state_r),
    .data_byte (s1_byte_r),
    .eom       (s1_eom_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!res.emit || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (s1_adv && res.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.in_byte;
      s1_eom_r  <= in_ch.end_of_message;
    end
    if (s1_adv && res.emit) begin
      out_word_r <= res.word;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.op_code        = out_word_r.op_code;
  assign out_ch.record_length  = out_word_r.record_length;
  assign out_ch.payload_byte   = out_word_r.payload_byte;
  assign out_ch.byte_valid     = out_word_r.byte_valid;
  assign out_ch.last_in_record = out_word_r.last_in_record;
  assign out_ch.error_code     = out_word_r.error_code;

  a_valid_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.byte_valid |-> out_word_r.error_code == ERR_NONE)
    else $error("payload word carries an error code");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.error_code != ERR_NONE) |-> out_word_r.last_in_record)
    else $error("error word not marked last");

  a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_PAY |-> state_r.remaining != '0)
    else $error("payload phase with nothing remaining");

  a_hdr_no_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase != PH_PAY |-> state_r.remaining == '0)
    else $error("header phase with payload count left");

  a_hold_stalled_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r) && $stable(state_r))
    else $error("stalled byte or parser state changed");

endmodule
